@@ rtl/aea_pkg.sv @@
// ----------------------------------------------------------------------------
// aea_pkg: shared definitions for the auto-exposure adapter
// Field widths, fixed-point constants, register indexes, the configuration
// and status structs, and the reciprocal table used by the series divider.
// ----------------------------------------------------------------------------
package aea_pkg;

   localparam int LUM_W = 16;
   localparam int DT_W = 16;
   localparam int SPEED_W = 16;
   localparam int EXPO_W = 24;

   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_RATE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_VALUE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPO_FLOOR = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPO_CEIL = 8'd3;

   localparam logic [SPEED_W-1:0] ADAPT_RATE_RST = 16'd256;
   localparam logic [EXPO_W-1:0] KEY_VALUE_RST = 24'd11796;
   localparam logic [EXPO_W-1:0] EXPO_FLOOR_RST = 24'd0;
   localparam logic [EXPO_W-1:0] EXPO_CEIL_RST = 24'hFFFFFF;
   localparam logic [EXPO_W-1:0] EXPOSURE_RST = 24'h010000;
   localparam logic [EXPO_W-1:0] EXPO_MAX = 24'hFFFFFF;

   // Range reduction, series and product widths.
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
   localparam int MAG_W = 41;
   localparam int Q_W = 10;
   localparam int CNT_W = 4;
   localparam int N_W = 11;
   localparam int SUM_W = 33;
   localparam int E_W = 57;
   localparam int K_W = 4;
   localparam int SHL_W = 5;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_W = MUL_A_W + MUL_B_W;
   localparam int LUM_SHIFT = 21;
   localparam int PROD_SHIFT = 8;

   localparam logic [CNT_W-1:0] RED_LAST_BIT = CNT_W'(Q_W - 1);
   localparam logic [K_W-1:0] TAYLOR_FIRST = 4'd2;
   localparam logic [K_W-1:0] TAYLOR_LAST = 4'd12;
   localparam logic [SUM_W-1:0] ONE_Q32 = 33'h1_0000_0000;

   typedef struct packed {
      logic [SPEED_W-1:0] adapt_rate;
      logic [EXPO_W-1:0] key_value;
      logic [EXPO_W-1:0] expo_floor;
      logic [EXPO_W-1:0] expo_ceil;
   } aea_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } aea_status_type;

   // floor(2^32 / k) for the series terms.
   function automatic logic [31:0] taylor_recip(input logic [K_W-1:0] k);
      logic [31:0] m;
      case (k)
         4'd2: m = 32'h80000000;
         4'd3: m = 32'h55555555;
         4'd4: m = 32'h40000000;
         4'd5: m = 32'h33333333;
         4'd6: m = 32'h2AAAAAAA;
         4'd7: m = 32'h24924924;
         4'd8: m = 32'h20000000;
         4'd9: m = 32'h1C71C71C;
         4'd10: m = 32'h19999999;
         4'd11: m = 32'h1745D174;
         4'd12: m = 32'h15555555;
         default: m = 32'h00000000;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/auto_exposure_adapter_top.sv @@
// ----------------------------------------------------------------------------
// auto_exposure_adapter_top: smoothed auto-exposure update
// Each accepted beat runs through the core to the result register; the first
// beat after reset skips the computation and returns the held exposure.
// The two exponential series run on the shared multiplier. A new beat is
// taken only once the core is idle again; req_stall holds off the next one.
// Synchronous reset restores the register defaults and an exposure of 1.0.
// ----------------------------------------------------------------------------
module auto_exposure_adapter_top
   import aea_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [LUM_W-1:0]    req_mean_log_lum,
   input  logic [DT_W-1:0]            req_frame_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [EXPO_W-1:0]          rsp_exposure,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   aea_cfg_type cfg_ff, cfg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [EXPO_W-1:0] rsp_exposure_ff, rsp_exposure_in;

   aea_status_type core_status;
   logic [EXPO_W-1:0] core_exposure;
   logic core_start;
   logic out_ready;

   assign csr_ready = 1'b1;
   assign req_stall = core_status.busy;
   assign core_start = req_valid && !req_stall;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ADAPT_RATE: cfg_in.adapt_rate = csr_wdata[SPEED_W-1:0];
            CSR_KEY_VALUE: cfg_in.key_value = csr_wdata[EXPO_W-1:0];
            CSR_EXPO_FLOOR: cfg_in.expo_floor = csr_wdata[EXPO_W-1:0];
            CSR_EXPO_CEIL: cfg_in.expo_ceil = csr_wdata[EXPO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_exposure_in = rsp_exposure_ff;
      if (core_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_exposure_in = core_exposure;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adapt_rate <= ADAPT_RATE_RST;
         cfg_ff.key_value <= KEY_VALUE_RST;
         cfg_ff.expo_floor <= EXPO_FLOOR_RST;
         cfg_ff.expo_ceil <= EXPO_CEIL_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_exposure_ff <= rsp_exposure_in;
   end

   aea_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .start        (core_start),
      .mean_log_lum (req_mean_log_lum),
      .frame_time   (req_frame_time),
      .out_ready    (out_ready),
      .status       (core_status),
      .exposure     (core_exposure)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_exposure = rsp_exposure_ff;

endmodule

@@ rtl/aea_core.sv @@
// ----------------------------------------------------------------------------
// aea_core: exposure update sequencer
// One shared multiplier and a compare/subtract stage evaluate two
// exponentials by range reduction and a truncated series, then form the
// target, the blend weight and the clamped exposure, which is held here.
// ----------------------------------------------------------------------------
module aea_core
   import aea_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  aea_cfg_type              cfg,
   input  logic                     start,
   input  logic signed [LUM_W-1:0]  mean_log_lum,
   input  logic [DT_W-1:0]          frame_time,
   input  logic                     out_ready,
   output aea_status_type           status,
   output logic [EXPO_W-1:0]        exposure
);

   typedef enum logic [16:0] {
      ST_IDLE    = 17'h00001,
      ST_RED     = 17'h00002,
      ST_RFIN    = 17'h00004,
      ST_TMUL    = 17'h00008,
      ST_TREC    = 17'h00010,
      ST_TCHK    = 17'h00020,
      ST_TADD    = 17'h00040,
      ST_SHIFT   = 17'h00080,
      ST_TGT_HI  = 17'h00100,
      ST_TGT_LO  = 17'h00200,
      ST_TGT_ADD = 17'h00400,
      ST_WPROD   = 17'h00800,
      ST_WSTART  = 17'h01000,
      ST_WGT     = 17'h02000,
      ST_BLEND   = 17'h04000,
      ST_APPLY   = 17'h08000,
      ST_OUT     = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic first_ff, first_in;
   logic [EXPO_W-1:0] cur_ff, cur_in;

   logic phase_ff, phase_in;
   logic [DT_W-1:0] dt_ff, dt_in;
   logic [MAG_W-1:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0] n_ff, n_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] term_ff, term_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [K_W-1:0] k_ff, k_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] q0_ff, q0_in;
   logic [E_W-1:0] e_ff, e_in;
   logic [EXPO_W-1:0] target_ff, target_in;
   logic [SUM_W-1:0] w_ff, w_in;
   logic [EXPO_W-1:0] diff_ff, diff_in;
   logic up_ff, up_in;
   logic [MUL_W-1:0] mul_ff, mul_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [LUM_W:0] lum_ext;
   logic [LUM_W:0] lum_abs;
   logic [MAG_W-1:0] red_cand;
   logic [31:0] r_sel;
   logic [31:0] chk;
   logic [31:0] quo;
   logic [N_W-1:0] sh_r;
   logic [EXPO_W:0] tsum;
   logic [EXPO_W-1:0] step;
   logic [EXPO_W-1:0] moved;
   logic [EXPO_W-1:0] low_bound;

   assign lum_ext = {mean_log_lum[LUM_W-1], mean_log_lum};
   assign lum_abs = lum_ext[LUM_W] ? (~lum_ext + (LUM_W+1)'(1)) : lum_ext;
   assign red_cand = MAG_W'(LN2_Q32) << cnt_ff;
   assign chk = x_ff - mul_ff[31:0];
   assign quo = (chk >= 32'(k_ff)) ? (q0_ff + 32'd1) : q0_ff;
   assign sh_r = N_W'(0) - n_ff;
   assign tsum = {1'b0, target_ff} + {1'b0, mul_ff[55:32]};
   assign step = mul_ff[55:32];
   assign moved = up_ff ? (cur_ff + step) : (cur_ff - step);
   assign low_bound = (moved < cfg.expo_floor) ? cfg.expo_floor : moved;

   always_comb begin
      if (!neg_ff) begin
         r_sel = rem_ff[31:0];
      end else if (rem_ff == MAG_W'(0)) begin
         r_sel = 32'd0;
      end else begin
         r_sel = LN2_Q32 - rem_ff[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      cur_in = cur_ff;
      phase_in = phase_ff;
      dt_in = dt_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      r_in = r_ff;
      term_in = term_ff;
      sum_in = sum_ff;
      k_in = k_ff;
      x_in = x_ff;
      q0_in = q0_ff;
      e_in = e_ff;
      target_in = target_ff;
      w_in = w_ff;
      diff_in = diff_ff;
      up_in = up_ff;
      mul_a = '0;
      mul_b = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (first_ff) begin
                  first_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  dt_in = frame_time;
                  phase_in = 1'b0;
                  rem_in = MAG_W'(lum_abs) << LUM_SHIFT;
                  neg_in = !mean_log_lum[LUM_W-1] && (mean_log_lum != '0);
                  q_in = '0;
                  cnt_in = RED_LAST_BIT;
                  state_in = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (rem_ff >= red_cand) begin
               rem_in = rem_ff - red_cand;
               q_in = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               q_in = {q_ff[Q_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = ST_RFIN;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_RFIN: begin
            if (!neg_ff) begin
               n_in = {1'b0, q_ff};
            end else if (rem_ff == MAG_W'(0)) begin
               n_in = ~{1'b0, q_ff} + N_W'(1);
            end else begin
               n_in = ~{1'b0, q_ff};
            end
            r_in = r_sel;
            term_in = r_sel;
            sum_in = ONE_Q32 + SUM_W'(r_sel);
            k_in = TAYLOR_FIRST;
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            mul_a = MUL_A_W'(term_ff);
            mul_b = r_ff;
            state_in = ST_TREC;
         end
         ST_TREC: begin
            mul_a = MUL_A_W'(mul_ff[63:32]);
            mul_b = taylor_recip(k_ff);
            x_in = mul_ff[63:32];
            state_in = ST_TCHK;
         end
         ST_TCHK: begin
            mul_a = MUL_A_W'(mul_ff[63:32]);
            mul_b = MUL_B_W'(k_ff);
            q0_in = mul_ff[63:32];
            state_in = ST_TADD;
         end
         ST_TADD: begin
            term_in = quo;
            sum_in = sum_ff + SUM_W'(quo);
            if (k_ff == TAYLOR_LAST) begin
               state_in = ST_SHIFT;
            end else begin
               k_in = k_ff + K_W'(1);
               state_in = ST_TMUL;
            end
         end
         ST_SHIFT: begin
            if (!n_ff[N_W-1]) begin
               e_in = E_W'(sum_ff) << n_ff[SHL_W-1:0];
            end else if (sh_r[N_W-1:6] != '0) begin
               e_in = '0;
            end else begin
               e_in = E_W'(sum_ff >> sh_r[5:0]);
            end
            state_in = phase_ff ? ST_WGT : ST_TGT_HI;
         end
         ST_TGT_HI: begin
            mul_a = MUL_A_W'(cfg.key_value);
            mul_b = MUL_B_W'(e_ff[E_W-1:32]);
            state_in = ST_TGT_LO;
         end
         ST_TGT_LO: begin
            if (mul_ff > MUL_W'(EXPO_MAX)) begin
               target_in = EXPO_MAX;
               state_in = ST_WPROD;
            end else begin
               target_in = mul_ff[EXPO_W-1:0];
               mul_a = MUL_A_W'(cfg.key_value);
               mul_b = e_ff[31:0];
               state_in = ST_TGT_ADD;
            end
         end
         ST_TGT_ADD: begin
            target_in = tsum[EXPO_W] ? EXPO_MAX : tsum[EXPO_W-1:0];
            state_in = ST_WPROD;
         end
         ST_WPROD: begin
            mul_a = MUL_A_W'(dt_ff);
            mul_b = MUL_B_W'(cfg.adapt_rate);
            state_in = ST_WSTART;
         end
         ST_WSTART: begin
            rem_in = MAG_W'(mul_ff[31:0]) << PROD_SHIFT;
            neg_in = (mul_ff[31:0] != 32'd0);
            q_in = '0;
            cnt_in = RED_LAST_BIT;
            phase_in = 1'b1;
            state_in = ST_RED;
         end
         ST_WGT: begin
            w_in = ONE_Q32 - e_ff[SUM_W-1:0];
            up_in = (target_ff >= cur_ff);
            diff_in = (target_ff >= cur_ff) ? (target_ff - cur_ff) : (cur_ff - target_ff);
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            mul_a = w_ff;
            mul_b = MUL_B_W'(diff_ff);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cur_in = (low_bound > cfg.expo_ceil) ? cfg.expo_ceil : low_bound;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mul_in = MUL_W'(mul_a) * MUL_W'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b1;
         cur_ff <= EXPOSURE_RST;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      dt_ff <= dt_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      r_ff <= r_in;
      term_ff <= term_in;
      sum_ff <= sum_in;
      k_ff <= k_in;
      x_ff <= x_in;
      q0_ff <= q0_in;
      e_ff <= e_in;
      target_ff <= target_in;
      w_ff <= w_in;
      diff_ff <= diff_in;
      up_ff <= up_in;
      mul_ff <= mul_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_OUT) && out_ready;
   assign exposure = cur_ff;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for auto_exposure_adapter_top
// A directed sequence covers the first frame after reset, the extremes of
// luminance, frame time and every register, and the clamp cases, including a
// minimum above the maximum. Three random phases then follow, each with its
// own idle mix, and a long receiver hold-off backs the block up. A fixed-point
// exposure predictor in the bench supplies the expected value of every beat.
// ----------------------------------------------------------------------------
module testbench
   import aea_pkg::*;
;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 130;
   localparam int PHASE_BEATS = 168;
   localparam int CONFIG_EVERY = 42;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 8'hFF;
   localparam logic signed [LUM_W-1:0] LUM_MIN = 16'sh8000;
   localparam logic signed [LUM_W-1:0] LUM_MAX = 16'sh7FFF;
   localparam longint LN2_WIDE = longint'(LN2_Q32);
   localparam logic [63:0] UNIT_Q32 = 64'h1_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [LUM_W-1:0] req_mean_log_lum = '0;
   logic [DT_W-1:0] req_frame_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [EXPO_W-1:0] rsp_exposure;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   aea_cfg_type cfg_shadow;
   logic [EXPO_W-1:0] held_exposure;
   logic first_frame_pending;
   logic [EXPO_W-1:0] expected_exposures[$];
   logic [EXPO_W-1:0] want_exposure;
   int error_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles_wanted = 0;
   int hold_left = 0;

   auto_exposure_adapter_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mean_log_lum(req_mean_log_lum),
      .req_frame_time(req_frame_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_exposure(rsp_exposure),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // The exponential takes a signed Q.32 argument and returns Q32.32.
   function automatic logic [63:0] exp_fixed(input longint y);
      longint n;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] total;
      if (y >= 0) begin
         n = y / LN2_WIDE;
      end else begin
         n = -((-y + LN2_WIDE - 1) / LN2_WIDE);
      end
      r = y - n * LN2_WIDE;
      term = UNIT_Q32;
      total = UNIT_Q32;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * r) >> 32) / 64'(k);
         total += term;
      end
      if (n >= 0) begin
         if (n > 24) return 64'd1 << 60;
         return total << n;
      end
      if (n <= -64) return 64'd0;
      return total >> (-n);
   endfunction

   function automatic logic [EXPO_W-1:0] next_exposure(input logic signed [LUM_W-1:0] lum,
                                                       input logic [DT_W-1:0] dt);
      longint lum_wide;
      logic [63:0] e;
      logic [63:0] target;
      logic [63:0] weight;
      logic [63:0] cur;
      logic [63:0] prod;
      if (first_frame_pending) begin
         first_frame_pending = 1'b0;
         return held_exposure;
      end
      lum_wide = lum;
      e = exp_fixed(-lum_wide * 64'sd2097152);
      target = 64'(cfg_shadow.key_value) * (e >> 32);
      if (target > 64'(EXPO_MAX)) begin
         target = 64'(EXPO_MAX);
      end else begin
         target += (64'(cfg_shadow.key_value) * (e & 64'hFFFF_FFFF)) >> 32;
         if (target > 64'(EXPO_MAX)) target = 64'(EXPO_MAX);
      end
      prod = 64'(dt) * 64'(cfg_shadow.adapt_rate);
      weight = UNIT_Q32 - exp_fixed(-longint'(prod << 8));
      cur = 64'(held_exposure);
      if (target >= cur) begin
         cur = cur + (((target - cur) * weight) >> 32);
      end else begin
         cur = cur - (((cur - target) * weight) >> 32);
      end
      if (cur < 64'(cfg_shadow.expo_floor)) cur = 64'(cfg_shadow.expo_floor);
      if (cur > 64'(cfg_shadow.expo_ceil)) cur = 64'(cfg_shadow.expo_ceil);
      held_exposure = cur[EXPO_W-1:0];
      return held_exposure;
   endfunction

   task automatic report_mismatch(input string what, input logic [EXPO_W-1:0] got,
                                  input logic [EXPO_W-1:0] want);
      $display("mismatch at %0t: %s, exposure %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_exposures.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_exposure, '0);
         end else begin
            want_exposure = expected_exposures.pop_front();
            if (rsp_exposure !== want_exposure) begin
               report_mismatch("wrong exposure", rsp_exposure, want_exposure);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles_wanted != 0) begin
         hold_left = hold_cycles_wanted;
         hold_cycles_wanted = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic send_frame(input logic signed [LUM_W-1:0] lum, input logic [DT_W-1:0] dt);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_mean_log_lum <= LUM_W'($urandom);
         req_frame_time <= DT_W'($urandom);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mean_log_lum <= lum;
      req_frame_time <= dt;
      do @(posedge clock); while (req_stall);
      expected_exposures = {expected_exposures, next_exposure(lum, dt)};
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_ADAPT_RATE: cfg_shadow.adapt_rate = value[SPEED_W-1:0];
         CSR_KEY_VALUE: cfg_shadow.key_value = value[EXPO_W-1:0];
         CSR_EXPO_FLOOR: cfg_shadow.expo_floor = value[EXPO_W-1:0];
         CSR_EXPO_CEIL: cfg_shadow.expo_ceil = value[EXPO_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_exposures.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_random_config();
      logic [SPEED_W-1:0] speed;
      logic [EXPO_W-1:0] key;
      logic [EXPO_W-1:0] lo;
      logic [EXPO_W-1:0] hi;
      case ($urandom_range(0, 9))
         0: speed = '0;
         1: speed = '1;
         2, 3, 4, 5: speed = SPEED_W'($urandom_range(16, 1024));
         default: speed = SPEED_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: key = '0;
         1: key = EXPO_MAX;
         2, 3, 4, 5, 6: key = EXPO_W'($urandom_range(2000, 40000));
         default: key = EXPO_W'($urandom);
      endcase
      lo = EXPO_W'($urandom_range(0, 24'h20000));
      hi = lo + EXPO_W'($urandom_range(24'h1000, 24'h80000));
      case ($urandom_range(0, 9))
         0: begin
            lo = EXPO_FLOOR_RST;
            hi = EXPO_CEIL_RST;
         end
         1: begin
            hi = EXPO_W'($urandom_range(0, 24'h10000));
            lo = hi + EXPO_W'($urandom_range(1, 24'h10000));
         end
         2: begin
            lo = EXPO_W'($urandom);
            hi = EXPO_W'($urandom);
            if (lo > hi) {lo, hi} = {hi, lo};
         end
         default: ;
      endcase
      write_reg(CSR_ADAPT_RATE, {8'($urandom), speed});
      write_reg(CSR_KEY_VALUE, key);
      write_reg(CSR_EXPO_FLOOR, lo);
      write_reg(CSR_EXPO_CEIL, hi);
   endtask

   task automatic test_first_frame();
      write_reg(CSR_EXPO_CEIL, 24'h000400);
      send_frame(LUM_MIN, 16'hFFFF);
      wait_for_idle();
      write_reg(CSR_EXPO_CEIL, EXPO_CEIL_RST);
   endtask

   task automatic test_field_extremes();
      send_frame(LUM_MAX, 16'hFFFF);
      send_frame(LUM_MIN, 16'hFFFF);
      send_frame(16'sd0, 16'h0001);
      send_frame(-16'sd1, 16'h8000);
      send_frame(16'sd1, 16'hFFFF);
      send_frame(16'sd0, 16'hFFFF);
      wait_for_idle();
   endtask

   task automatic test_weight_extremes();
      write_reg(CSR_ADAPT_RATE, '0);
      send_frame(16'sd512, 16'hFFFF);
      wait_for_idle();
      write_reg(CSR_ADAPT_RATE, 24'h00FFFF);
      send_frame(-16'sd1024, 16'hFFFF);
      send_frame(16'sd2048, 16'h0000);
      wait_for_idle();
      write_reg(CSR_ADAPT_RATE, 24'(ADAPT_RATE_RST));
   endtask

   task automatic test_key_extremes();
      write_reg(CSR_KEY_VALUE, '0);
      send_frame(16'sd0, 16'hFFFF);
      wait_for_idle();
      write_reg(CSR_KEY_VALUE, EXPO_MAX);
      send_frame(16'sd0, 16'hFFFF);
      send_frame(LUM_MIN, 16'h4000);
      wait_for_idle();
      write_reg(CSR_KEY_VALUE, KEY_VALUE_RST);
   endtask

   task automatic test_clamp_bounds();
      write_reg(CSR_EXPO_FLOOR, 24'h300000);
      write_reg(CSR_EXPO_CEIL, 24'h100000);
      send_frame(16'sd100, 16'h2000);
      wait_for_idle();
      write_reg(CSR_EXPO_FLOOR, '0);
      write_reg(CSR_EXPO_CEIL, '0);
      send_frame(-16'sd3000, 16'hFFFF);
      wait_for_idle();
      write_reg(CSR_EXPO_FLOOR, EXPO_MAX);
      write_reg(CSR_EXPO_CEIL, EXPO_MAX);
      send_frame(LUM_MAX, 16'hFFFF);
      wait_for_idle();
      write_reg(CSR_UNMAPPED, 24'h5A5A5A);
      write_reg(CSR_EXPO_FLOOR, EXPO_FLOOR_RST);
      write_reg(CSR_EXPO_CEIL, EXPO_CEIL_RST);
      send_frame(16'sd700, 16'h1000);
      wait_for_idle();
   endtask

   task automatic send_random_frame();
      logic signed [LUM_W-1:0] lum;
      logic [DT_W-1:0] dt;
      if ($urandom_range(0, 2) == 0) begin
         lum = LUM_W'($urandom);
      end else begin
         lum = LUM_W'(int'($urandom_range(0, 12288)) - 6144);
      end
      if ($urandom_range(0, 1) == 0) begin
         dt = DT_W'($urandom);
      end else begin
         dt = DT_W'($urandom_range(0, 8192));
      end
      send_frame(lum, dt);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i % CONFIG_EVERY == 0) begin
            wait_for_idle();
            pick_random_config();
         end
         send_random_frame();
      end
      wait_for_idle();
   endtask

   // The receiver refuses beats for a long stretch while the sender keeps
   // offering, so the block fills up and stalls its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_cycles_wanted = 800;
      for (int i = 0; i < 12; i++) begin
         send_random_frame();
      end
      wait_for_idle();
   endtask

   initial begin
      cfg_shadow.adapt_rate = ADAPT_RATE_RST;
      cfg_shadow.key_value = KEY_VALUE_RST;
      cfg_shadow.expo_floor = EXPO_FLOOR_RST;
      cfg_shadow.expo_ceil = EXPO_CEIL_RST;
      held_exposure = EXPOSURE_RST;
      first_frame_pending = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 10;
      rsp_stall_pct = 30;
      test_first_frame();
      test_field_extremes();
      test_weight_extremes();
      test_key_extremes();
      test_clamp_bounds();
      test_random_traffic(PHASE_BEATS, 27, 79);
      test_random_traffic(PHASE_BEATS, 79, 27);
      test_backpressure();
      test_random_traffic(PHASE_BEATS, 0, 0);
      if (error_count == 0 && expected_exposures.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/aea_pkg.sv
rtl/aea_core.sv
rtl/auto_exposure_adapter_top.sv
tb/testbench.sv
